// ===== rtl/dotted_line_rasterizer_macros.svh =====
// Assertion macros for the dotted line rasterizer.
`ifndef DOTTED_LINE_RASTERIZER_MACROS_SVH
`define DOTTED_LINE_RASTERIZER_MACROS_SVH

`ifndef SYNTHESIS

`define DLR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dotted_line_rasterizer: assertion failed");

`define DLR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dotted_line_rasterizer: assertion failed");

`else

`define DLR_ASSERT_IMPL(label, ante, cons)

`define DLR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/dlr_pkg.sv =====
// Package of shared constants and types for the dotted line rasterizer.
package dlr_pkg;

  localparam int unsigned COORD_BITS       = 12;
  localparam int unsigned PERIOD_BITS      = 8;
  localparam logic [7:0]  DOT_PERIOD_RESET = 8'd8;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  localparam logic [1:0] DIR_ZERO = 2'b00;
  localparam logic [1:0] DIR_POS  = 2'b01;
  localparam logic [1:0] DIR_NEG  = 2'b11;

  typedef struct packed {
    logic active;
    logic steps_zero;
  } dlr_status_t;

endpackage

// ===== rtl/dlr_in_stage.sv =====
// Input register stage holding one accepted item until the step core takes it.
module dlr_in_stage #(
  parameter int unsigned COORD_BITS = dlr_pkg::COORD_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         operation_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic                         take_i,
  output logic                         item_valid_o,
  output logic                         operation_o,
  output logic signed [COORD_BITS-1:0] start_x_o,
  output logic signed [COORD_BITS-1:0] start_y_o,
  output logic signed [COORD_BITS-1:0] end_x_o,
  output logic signed [COORD_BITS-1:0] end_y_o
);

  logic                         valid_q, valid_d;
  logic                         load;
  logic                         op_q;
  logic signed [COORD_BITS-1:0] sx_q, sy_q, ex_q, ey_q;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q <= operation_i;
      sx_q <= start_x_i;
      sy_q <= start_y_i;
      ex_q <= end_x_i;
      ey_q <= end_y_i;
    end
  end

  assign item_valid_o = valid_q;
  assign operation_o  = op_q;
  assign start_x_o    = sx_q;
  assign start_y_o    = sy_q;
  assign end_x_o      = ex_q;
  assign end_y_o      = ey_q;

endmodule

// ===== rtl/dlr_core.sv =====
// Line state, at most one Bresenham step per transfer, dot period register and result register.
module dlr_core #(
  parameter int unsigned COORD_BITS = dlr_pkg::COORD_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_write_i,
  input  logic [dlr_pkg::PERIOD_BITS-1:0]      cfg_data_i,
  input  logic                                 item_valid_i,
  input  logic                                 operation_i,
  input  logic signed [COORD_BITS-1:0]         start_x_i,
  input  logic signed [COORD_BITS-1:0]         start_y_i,
  input  logic signed [COORD_BITS-1:0]         end_x_i,
  input  logic signed [COORD_BITS-1:0]         end_y_i,
  output logic                                 take_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 plot_o,
  output logic signed [COORD_BITS-1:0]         pixel_x_o,
  output logic signed [COORD_BITS-1:0]         pixel_y_o,
  output logic                                 done_res_o,
  output dlr_pkg::dlr_status_t                 status_o
);

  localparam int unsigned EW = COORD_BITS + 3;
  localparam int unsigned PB = dlr_pkg::PERIOD_BITS;

  logic [PB-1:0]               period_q;
  logic signed [COORD_BITS-1:0] wx_q, wx_d, wy_q, wy_d;
  logic signed [EW-1:0]        err_q, err_d;
  logic [COORD_BITS-1:0]       maj_q, maj_d, min_q, min_d, left_q, left_d;
  logic [PB-1:0]               cnt_q, cnt_d;
  logic [1:0]                  dx_q, dx_d, dy_q, dy_d;
  logic                        steep_q, steep_d, active_q, active_d;

  logic                        ov_q;
  logic                        plot_q, plot_d, done_q, done_d;
  logic signed [COORD_BITS-1:0] px_q, py_q;

  logic signed [COORD_BITS:0]  ddx, ddy;
  logic [COORD_BITS:0]         adx_w, ady_w;
  logic [COORD_BITS-1:0]       adx, ady;
  logic                        st_steep;
  logic [COORD_BITS-1:0]       st_maj, st_min;
  logic signed [EW-1:0]        maj2, min2, err_dec;
  logic                        err_pos;
  logic signed [COORD_BITS-1:0] stepx, stepy;
  logic [PB-1:0]               cnt_next;
  logic                        hit;

  assign take_o = item_valid_i && (!ov_q || !out_stall_i);

  assign ddx   = {end_x_i[COORD_BITS-1], end_x_i} - {start_x_i[COORD_BITS-1], start_x_i};
  assign ddy   = {end_y_i[COORD_BITS-1], end_y_i} - {start_y_i[COORD_BITS-1], start_y_i};
  assign adx_w = ddx[COORD_BITS] ? -ddx : ddx;
  assign ady_w = ddy[COORD_BITS] ? -ddy : ddy;
  assign adx   = adx_w[COORD_BITS-1:0];
  assign ady   = ady_w[COORD_BITS-1:0];
  assign st_steep = ady > adx;
  assign st_maj   = st_steep ? ady : adx;
  assign st_min   = st_steep ? adx : ady;

  assign maj2    = {2'b00, maj_q, 1'b0};
  assign min2    = {2'b00, min_q, 1'b0};
  assign err_pos = !err_q[EW-1];
  assign err_dec = err_pos ? (err_q - maj2) : err_q;
  assign stepx   = {{(COORD_BITS-2){dx_q[1]}}, dx_q};
  assign stepy   = {{(COORD_BITS-2){dy_q[1]}}, dy_q};

  assign cnt_next = cnt_q + {{(PB-1){1'b0}}, 1'b1};
  assign hit      = cnt_next == period_q;

  always_comb begin
    wx_d     = wx_q;
    wy_d     = wy_q;
    err_d    = err_q;
    maj_d    = maj_q;
    min_d    = min_q;
    left_d   = left_q;
    cnt_d    = cnt_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    steep_d  = steep_q;
    active_d = active_q;
    plot_d   = 1'b0;
    done_d   = 1'b1;
    if (operation_i == dlr_pkg::OP_START) begin
      dx_d     = (ddx == '0) ? dlr_pkg::DIR_ZERO
                             : (ddx[COORD_BITS] ? dlr_pkg::DIR_NEG : dlr_pkg::DIR_POS);
      dy_d     = (ddy == '0) ? dlr_pkg::DIR_ZERO
                             : (ddy[COORD_BITS] ? dlr_pkg::DIR_NEG : dlr_pkg::DIR_POS);
      steep_d  = st_steep;
      maj_d    = st_maj;
      min_d    = st_min;
      err_d    = {2'b00, st_min, 1'b0} - {3'b000, st_maj};
      wx_d     = start_x_i;
      wy_d     = start_y_i;
      left_d   = st_maj;
      cnt_d    = '0;
      active_d = st_maj != '0;
      plot_d   = 1'b1;
      done_d   = st_maj == '0;
    end else if (active_q) begin
      if (steep_q) begin
        wy_d = wy_q + stepy;
        if (err_pos) begin
          wx_d = wx_q + stepx;
        end
      end else begin
        wx_d = wx_q + stepx;
        if (err_pos) begin
          wy_d = wy_q + stepy;
        end
      end
      err_d    = err_dec + min2;
      cnt_d    = hit ? '0 : cnt_next;
      left_d   = left_q - {{(COORD_BITS-1){1'b0}}, 1'b1};
      active_d = left_q != {{(COORD_BITS-1){1'b0}}, 1'b1};
      plot_d   = hit;
      done_d   = !active_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= dlr_pkg::DOT_PERIOD_RESET;
      wx_q     <= '0;
      wy_q     <= '0;
      err_q    <= '0;
      maj_q    <= '0;
      min_q    <= '0;
      left_q   <= '0;
      cnt_q    <= '0;
      dx_q     <= dlr_pkg::DIR_ZERO;
      dy_q     <= dlr_pkg::DIR_ZERO;
      steep_q  <= 1'b0;
      active_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      if (cfg_write_i) begin
        period_q <= cfg_data_i;
      end
      if (take_o) begin
        wx_q     <= wx_d;
        wy_q     <= wy_d;
        err_q    <= err_d;
        maj_q    <= maj_d;
        min_q    <= min_d;
        left_q   <= left_d;
        cnt_q    <= cnt_d;
        dx_q     <= dx_d;
        dy_q     <= dy_d;
        steep_q  <= steep_d;
        active_q <= active_d;
      end
      if (take_o) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      plot_q <= plot_d;
      done_q <= done_d;
      px_q   <= wx_d;
      py_q   <= wy_d;
    end
  end

  assign out_valid_o         = ov_q;
  assign plot_o              = plot_q;
  assign pixel_x_o           = px_q;
  assign pixel_y_o           = py_q;
  assign done_res_o          = done_q;
  assign status_o.active     = active_q;
  assign status_o.steps_zero = left_q == '0;

endmodule

// ===== rtl/dotted_line_rasterizer.sv =====
// Top level of the dotted line rasterizer: input register, step core, checks.
// Throughput: one item per cycle while out_stall_i is low; each step is one add and compare
// on the line state. An item goes through the input register, then the result register.
// Reset: rst_ni low clears all line state to idle and sets the dot period to 8.
// Configuration writes are always ready and take effect on the next cycle.
`include "dotted_line_rasterizer_macros.svh"

module dotted_line_rasterizer #(
  parameter int unsigned COORD_BITS = dlr_pkg::COORD_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [dlr_pkg::PERIOD_BITS-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 operation_i,
  input  logic signed [COORD_BITS-1:0]         start_x_i,
  input  logic signed [COORD_BITS-1:0]         start_y_i,
  input  logic signed [COORD_BITS-1:0]         end_x_i,
  input  logic signed [COORD_BITS-1:0]         end_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 plot_o,
  output logic signed [COORD_BITS-1:0]         pixel_x_o,
  output logic signed [COORD_BITS-1:0]         pixel_y_o,
  output logic                                 done_res_o
);

  logic                         item_valid, item_op, take;
  logic signed [COORD_BITS-1:0] item_sx, item_sy, item_ex, item_ey;
  dlr_pkg::dlr_status_t         status;

  assign cfg_ready_o = 1'b1;

  dlr_in_stage #(
    .COORD_BITS(COORD_BITS)
  ) u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .take_i      (take),
    .item_valid_o(item_valid),
    .operation_o (item_op),
    .start_x_o   (item_sx),
    .start_y_o   (item_sy),
    .end_x_o     (item_ex),
    .end_y_o     (item_ey)
  );

  dlr_core #(
    .COORD_BITS(COORD_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_write_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .item_valid_i(item_valid),
    .operation_i (item_op),
    .start_x_i   (item_sx),
    .start_y_i   (item_sy),
    .end_x_i     (item_ex),
    .end_y_i     (item_ey),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .plot_o      (plot_o),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .done_res_o  (done_res_o),
    .status_o    (status)
  );

  `DLR_ASSERT_IMPL(a_stall_needs_item, in_stall_o, item_valid)
  `DLR_ASSERT_IMPL(a_active_has_steps, 1'b1, status.active == !status.steps_zero)
  `DLR_ASSERT_NEXT(a_take_gives_result, take, out_valid_o)

endmodule

// ===== tb/dotted_line_rasterizer_test.sv =====
// Self-checking testbench for the dotted line rasterizer, with a predicting scoreboard.
`timescale 1ns / 1ps

module dotted_line_rasterizer_test;

  typedef logic signed [dlr_pkg::COORD_BITS-1:0] coord_t;

  typedef struct {
    logic   plot;
    coord_t x;
    coord_t y;
    logic   done;
  } pixel_t;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;

  class dot_scoreboard;
    logic [dlr_pkg::PERIOD_BITS-1:0] period    = dlr_pkg::DOT_PERIOD_RESET;
    coord_t                          walk_x    = '0;
    coord_t                          walk_y    = '0;
    int                              err_acc   = 0;
    int                              major_d   = 0;
    int                              minor_d   = 0;
    int                              steps_due = 0;
    logic [dlr_pkg::PERIOD_BITS-1:0] dot_count = '0;
    logic [1:0]                      dir_x     = dlr_pkg::DIR_ZERO;
    logic [1:0]                      dir_y     = dlr_pkg::DIR_ZERO;
    bit                              steep     = 1'b0;
    bit                              active    = 1'b0;
    pixel_t                          pending_pixels[$];
    int                              errors    = 0;

    function logic [1:0] dir_code(int d);
      if (d > 0) return dlr_pkg::DIR_POS;
      if (d < 0) return dlr_pkg::DIR_NEG;
      return dlr_pkg::DIR_ZERO;
    endfunction

    function coord_t unit_step(logic [1:0] d);
      case (d)
        dlr_pkg::DIR_POS: return coord_t'(1);
        dlr_pkg::DIR_NEG: return coord_t'(-1);
        default:          return '0;
      endcase
    endfunction

    function void note_item(logic op, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
      int                              ddx;
      int                              ddy;
      int                              adx;
      int                              ady;
      logic [dlr_pkg::PERIOD_BITS-1:0] next_count;
      logic                            hit;
      pixel_t                          px;
      if (op == dlr_pkg::OP_START) begin
        ddx       = int'(ex) - int'(sx);
        ddy       = int'(ey) - int'(sy);
        adx       = (ddx < 0) ? -ddx : ddx;
        ady       = (ddy < 0) ? -ddy : ddy;
        dir_x     = dir_code(ddx);
        dir_y     = dir_code(ddy);
        steep     = ady > adx;
        major_d   = steep ? ady : adx;
        minor_d   = steep ? adx : ady;
        err_acc   = 2 * minor_d - major_d;
        walk_x    = sx;
        walk_y    = sy;
        steps_due = major_d;
        dot_count = '0;
        active    = steps_due != 0;
        px = '{plot: 1'b1, x: walk_x, y: walk_y, done: !active};
      end else if (!active) begin
        px = '{plot: 1'b0, x: walk_x, y: walk_y, done: 1'b1};
      end else begin
        if (err_acc >= 0) begin
          if (steep) walk_x = walk_x + unit_step(dir_x);
          else       walk_y = walk_y + unit_step(dir_y);
          err_acc -= 2 * major_d;
        end
        if (steep) walk_y = walk_y + unit_step(dir_y);
        else       walk_x = walk_x + unit_step(dir_x);
        err_acc += 2 * minor_d;
        next_count = dot_count + 1'b1;
        hit        = next_count == period;
        dot_count  = hit ? '0 : next_count;
        steps_due -= 1;
        active     = steps_due > 0;
        px = '{plot: hit, x: walk_x, y: walk_y, done: !active};
      end
      pending_pixels.push_back(px);
    endfunction

    function void report_field(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(logic plot, coord_t x, coord_t y, logic done);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        $display("%0t: result with none expected, got plot %0d x %0d y %0d done %0d",
                 $time, plot, x, y, done);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      report_field("plot", 32'(want.plot), 32'(plot));
      report_field("pixel_x", 32'(want.x), 32'(x));
      report_field("pixel_y", 32'(want.y), 32'(y));
      report_field("done_res", 32'(want.done), 32'(done));
    endfunction

    function void flush_check();
      if (pending_pixels.size() != 0) begin
        $display("%0t: %0d results never arrived", $time, pending_pixels.size());
        errors += pending_pixels.size();
      end
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni      = 1'b0;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [dlr_pkg::PERIOD_BITS-1:0] cfg_data_i  = '0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  logic                            operation_i = dlr_pkg::OP_START;
  coord_t                          start_x_i   = '0;
  coord_t                          start_y_i   = '0;
  coord_t                          end_x_i     = '0;
  coord_t                          end_y_i     = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic                            plot_o;
  coord_t                          pixel_x_o;
  coord_t                          pixel_y_o;
  logic                            done_res_o;

  dot_scoreboard sb = new;
  bit            no_idle    = 1'b0;
  int            items_sent = 0;

  dotted_line_rasterizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .plot_o      (plot_o),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .done_res_o  (done_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int rand_coord();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  function automatic int near_coord(int c, int span);
    int d;
    d = int'($urandom_range(0, 2 * span)) - span;
    if (c + d > 2047 || c + d < -2048) d = -d;
    return c + d;
  endfunction

  task automatic send_item(logic op, int sx, int sy, int ex, int ey);
    int     gap;
    coord_t csx;
    coord_t csy;
    coord_t cex;
    coord_t cey;
    csx = coord_t'(sx);
    csy = coord_t'(sy);
    cex = coord_t'(ex);
    cey = coord_t'(ey);
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    start_x_i   <= csx;
    start_y_i   <= csy;
    end_x_i     <= cex;
    end_y_i     <= cey;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(op, csx, csy, cex, cey);
    items_sent++;
  endtask

  task automatic send_line(int sx, int sy, int ex, int ey, int adv);
    send_item(dlr_pkg::OP_START, sx, sy, ex, ey);
    repeat (adv)
      send_item(dlr_pkg::OP_ADVANCE, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic random_line();
    int sx;
    int sy;
    int ex;
    int ey;
    int span;
    int n;
    int m;
    int adv;
    no_idle = ($urandom_range(0, 5) == 0);
    sx = rand_coord();
    sy = rand_coord();
    if ($urandom_range(0, 7) == 0) begin
      ex  = rand_coord();
      ey  = rand_coord();
      adv = $urandom_range(1, 16);
    end else begin
      span = ($urandom_range(0, 4) == 0) ? 60 : 12;
      ex   = near_coord(sx, span);
      ey   = near_coord(sy, span);
      n    = (ex > sx) ? ex - sx : sx - ex;
      m    = (ey > sy) ? ey - sy : sy - ey;
      if (m > n) n = m;
      adv  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : n + $urandom_range(0, 2);
    end
    send_line(sx, sy, ex, ey, adv);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_pixels.size() != 0);
  endtask

  task automatic write_period(logic [dlr_pkg::PERIOD_BITS-1:0] p);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= p;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.period = p;
  endtask

  initial begin
    int hold;
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 3);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(rst_ni && out_valid_o));
      sb.check_pixel(plot_o, pixel_x_o, pixel_y_o, done_res_o);
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int periods[7];
    int phase_end;
    int sx;
    int sy;
    int ex;
    int ey;
    periods = '{1, 255, 0, 2, 5, 0, 0};
    periods[5] = $urandom_range(1, 255);
    periods[6] = $urandom_range(1, 255);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(dlr_pkg::OP_ADVANCE, 2047, -2048, 2047, -2048);
    send_item(dlr_pkg::OP_START, 2047, -2048, 2047, -2048);
    send_item(dlr_pkg::OP_ADVANCE, -2048, 2047, -2048, 2047);
    send_line(-2048, -2048, 2047, 2047, 2);
    send_line(2047, 2047, -2048, -2048, 1);
    send_line(0, 0, 3, -8, 9);
    send_line(-100, 5, 100, 5, 5);
    drain();
    write_period(3);
    repeat (3) send_item(dlr_pkg::OP_ADVANCE, 0, 0, 0, 0);

    foreach (periods[i]) begin
      drain();
      write_period(periods[i][dlr_pkg::PERIOD_BITS-1:0]);
      phase_end = items_sent + 100;
      if (periods[i] == 0 || periods[i] == 255) begin
        no_idle = 1'b0;
        sx = int'($urandom_range(0, 500)) - 2048;
        ex = sx + 300 + int'($urandom_range(0, 1000));
        sy = rand_coord();
        ey = near_coord(sy, 200);
        if ($urandom_range(0, 1) == 1) send_line(sy, sx, ey, ex, 258);
        else                           send_line(sx, sy, ex, ey, 258);
      end
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 30) == 0) drain();
        if ($urandom_range(0, 6) == 0)
          send_item(1'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord());
        else
          random_line();
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sb.flush_check();
    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dlr_pkg.sv
rtl/dlr_in_stage.sv
rtl/dlr_core.sv
rtl/dotted_line_rasterizer.sv
tb/dotted_line_rasterizer_test.sv
